>>> hw/rtl/epr_pkg.sv
// Shared types, constants and the arctangent table for the Euler point rotation unit.
package epr_pkg;

  localparam int CORDIC_N = 30;
  localparam int CW       = 34;

  // Angles in Q16.16 degrees.
  localparam logic [33:0] FULL_DEG    = 34'd23592960;
  localparam logic [33:0] HALF_DEG    = 34'd11796480;
  localparam logic [33:0] ANG_OFFSET  = 34'd2170552320;
  localparam logic signed [25:0] QUARTER_DEG = 26'sd5898240;
  localparam logic signed [25:0] HALF_DEG_S  = 26'sd11796480;
  localparam logic signed [25:0] FULL_DEG_S  = 26'sd23592960;

  // Degrees to Q2.30 radians scale, split into two halves of a 2^44 constant.
  localparam logic signed [21:0] D2R_HI = 22'sd292817;
  localparam logic signed [21:0] D2R_LO = 22'sd690507;

  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } point_t;

  function automatic logic signed [CW-1:0] atan_q30(input int idx);
    logic signed [CW-1:0] r;
    begin
      case (idx)
        0: r = 34'sd843314857;
        1: r = 34'sd497837829;
        2: r = 34'sd263043837;
        3: r = 34'sd133525159;
        4: r = 34'sd67021687;
        5: r = 34'sd33543516;
        6: r = 34'sd16775851;
        7: r = 34'sd8388437;
        8: r = 34'sd4194283;
        9: r = 34'sd2097149;
        default: r = 34'sd1 <<< (30 - idx);
      endcase
      return r;
    end
  endfunction

endpackage

>>> hw/rtl/euler_xyz_point_rotate_unit.sv
// Top level of the Euler X-Y-Z point rotation unit.
//
//   Channel  Direction  Ports
//   in       request    in_valid, in_stall, in_angle_x/y/z, in_point_x/y/z
//   out      result     out_valid, out_stall, out_x, out_y, out_z
//
// The unit takes one request every cycle unless a stalled result holds the chain.
// The chain is an angle reduction front end, 30 CORDIC cells, a rounding stage and,
// for each of the three axis rotations, a product and a round and saturate stage.
// Reset (rst_n low, synchronous) clears the valid bits of every stage.
// While a result is waiting and out_stall is high, the whole chain holds and
// in_stall is raised; the chain moves again as soon as the result is taken.
module euler_xyz_point_rotate_unit #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_angle_x,
  input  logic signed [31:0] in_angle_y,
  input  logic signed [31:0] in_angle_z,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z
);

  localparam int F        = TRIG_FRAC_BITS;
  localparam int TW       = F + 2;
  localparam int TRIG_LAT = 12 + epr_pkg::CORDIC_N + 1;
  localparam int VLAT     = TRIG_LAT + 6;

  // Every stage advances together; only a waiting, stalled result holds them.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic v_r [0:VLAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VLAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 1; i < VLAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  assign out_valid = v_r[VLAT-1];

  // The point waits beside the trig lanes until its cosines and sines are ready.
  epr_pkg::point_t pd_r [0:TRIG_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r[0] <= '{px: in_point_x, py: in_point_y, pz: in_point_z};
      for (int i = 1; i < TRIG_LAT; i++) begin
        pd_r[i] <= pd_r[i-1];
      end
    end
  end

  // Three independent trig lanes, one per angle, each a reduction front end
  // followed by a row of CORDIC cells and a rounding stage.
  logic signed [31:0]    ang [0:2];
  logic signed [TW-1:0]  tc [0:2];
  logic signed [TW-1:0]  ts [0:2];
  logic                  tz [0:2];

  assign ang[0] = in_angle_x;
  assign ang[1] = in_angle_y;
  assign ang[2] = in_angle_z;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    epr_pkg::cordic_t cc [0:epr_pkg::CORDIC_N];

    epr_reduce u_reduce (
      .clk    (clk),
      .en     (en),
      .ang_i  (ang[a]),
      .start_o(cc[0])
    );

    for (genvar i = 0; i < epr_pkg::CORDIC_N; i++) begin : g_cell
      epr_cordic_cell #(.IDX(i)) u_cell (
        .clk(clk),
        .en (en),
        .d_i(cc[i]),
        .d_o(cc[i+1])
      );
    end

    epr_trig_round #(.F(F)) u_round (
      .clk   (clk),
      .en    (en),
      .d_i   (cc[epr_pkg::CORDIC_N]),
      .c_o   (tc[a]),
      .s_o   (ts[a]),
      .zero_o(tz[a])
    );
  end

  // The Y and Z trig values are delayed to meet the point at their own stage.
  logic signed [TW-1:0] yc_r [0:1];
  logic signed [TW-1:0] ys_r [0:1];
  logic                 yz_r [0:1];
  logic signed [TW-1:0] zc_r [0:3];
  logic signed [TW-1:0] zs_r [0:3];
  logic                 zz_r [0:3];

  always_ff @(posedge clk) begin
    if (en) begin
      yc_r[0] <= tc[1];
      ys_r[0] <= ts[1];
      yz_r[0] <= tz[1];
      yc_r[1] <= yc_r[0];
      ys_r[1] <= ys_r[0];
      yz_r[1] <= yz_r[0];
      zc_r[0] <= tc[2];
      zs_r[0] <= ts[2];
      zz_r[0] <= tz[2];
      for (int i = 1; i < 4; i++) begin
        zc_r[i] <= zc_r[i-1];
        zs_r[i] <= zs_r[i-1];
        zz_r[i] <= zz_r[i-1];
      end
    end
  end

  epr_pkg::point_t p1, p2, p3;

  epr_rotate #(.F(F), .AXIS(epr_pkg::AXIS_X)) u_rot_x (
    .clk(clk), .en(en), .pt_i(pd_r[TRIG_LAT-1]),
    .c_i(tc[0]), .s_i(ts[0]), .zero_i(tz[0]), .pt_o(p1)
  );

  epr_rotate #(.F(F), .AXIS(epr_pkg::AXIS_Y)) u_rot_y (
    .clk(clk), .en(en), .pt_i(p1),
    .c_i(yc_r[1]), .s_i(ys_r[1]), .zero_i(yz_r[1]), .pt_o(p2)
  );

  epr_rotate #(.F(F), .AXIS(epr_pkg::AXIS_Z)) u_rot_z (
    .clk(clk), .en(en), .pt_i(p2),
    .c_i(zc_r[3]), .s_i(zs_r[3]), .zero_i(zz_r[3]), .pt_o(p3)
  );

  assign out_x = p3.px;
  assign out_y = p3.py;
  assign out_z = p3.pz;

  // The input is held back only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");

  // A cycle that moves the chain with no request leaves a bubble at its head.
  a_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (en && !in_valid) |=> !v_r[0])
    else $error("bubble not inserted");

  // The rounded cosine of the X lane never leaves the range of plus or minus one.
  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[TRIG_LAT-1] |-> ((tc[0] <= (TW'(1) <<< F)) && (tc[0] >= -(TW'(1) <<< F))))
    else $error("cosine out of range");

endmodule

>>> hw/rtl/epr_reduce.sv
// Angle reduction modulo 360, quadrant fold and conversion to Q2.30 radians.
module epr_reduce (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    ang_i,
  output epr_pkg::cordic_t      start_o
);

  logic [33:0]        a_r [0:8];
  logic               zf_r [0:10];
  logic signed [25:0] m_r;
  logic               ng_r [0:1];
  logic signed [47:0] ph_r;
  logic signed [47:0] pl_r;
  logic [33:0]        a_nxt;
  logic signed [25:0] m0;
  logic signed [25:0] m_nxt;
  logic               ng_nxt;
  logic signed [63:0] sum;

  assign a_nxt = {{2{ang_i[31]}}, ang_i} + epr_pkg::ANG_OFFSET;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r[0]  <= a_nxt;
      zf_r[0] <= (ang_i == 32'sd0);
    end
  end

  // Restoring reduction: one multiple of 360 degrees tested per stage.
  for (genvar j = 1; j <= 8; j++) begin : g_sub
    localparam logic [33:0] SUB = epr_pkg::FULL_DEG << (8 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        a_r[j]  <= (a_r[j-1] >= SUB) ? a_r[j-1] - SUB : a_r[j-1];
        zf_r[j] <= zf_r[j-1];
      end
    end
  end

  always_comb begin
    m0 = $signed({1'b0, a_r[8][24:0]});
    if (a_r[8] >= epr_pkg::HALF_DEG) begin
      m0 = m0 - epr_pkg::FULL_DEG_S;
    end
    m_nxt  = m0;
    ng_nxt = 1'b0;
    if (m0 > epr_pkg::QUARTER_DEG) begin
      m_nxt  = m0 - epr_pkg::HALF_DEG_S;
      ng_nxt = 1'b1;
    end else if (m0 < -epr_pkg::QUARTER_DEG) begin
      m_nxt  = m0 + epr_pkg::HALF_DEG_S;
      ng_nxt = 1'b1;
    end
  end

  assign sum = (64'(ph_r) <<< 20) + 64'(pl_r) + (64'sd1 <<< 29);

  always_ff @(posedge clk) begin
    if (en) begin
      m_r      <= m_nxt;
      ng_r[0]  <= ng_nxt;
      zf_r[9]  <= zf_r[8];
      ph_r     <= 48'(m_r) * 48'(epr_pkg::D2R_HI);
      pl_r     <= 48'(m_r) * 48'(epr_pkg::D2R_LO);
      ng_r[1]  <= ng_r[0];
      zf_r[10] <= zf_r[9];
      start_o.x    <= epr_pkg::GAIN_Q30;
      start_o.y    <= '0;
      start_o.z    <= sum[30 +: epr_pkg::CW];
      start_o.neg  <= ng_r[1];
      start_o.zero <= zf_r[10];
    end
  end

endmodule

>>> hw/rtl/epr_cordic_cell.sv
// One rotation-mode CORDIC iteration with its output register.
module epr_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             en,
  input  epr_pkg::cordic_t d_i,
  output epr_pkg::cordic_t d_o
);

  localparam logic signed [epr_pkg::CW-1:0] ATAN = epr_pkg::atan_q30(IDX);

  always_ff @(posedge clk) begin
    if (en) begin
      if (d_i.z >= 0) begin
        d_o.x <= d_i.x - (d_i.y >>> IDX);
        d_o.y <= d_i.y + (d_i.x >>> IDX);
        d_o.z <= d_i.z - ATAN;
      end else begin
        d_o.x <= d_i.x + (d_i.y >>> IDX);
        d_o.y <= d_i.y - (d_i.x >>> IDX);
        d_o.z <= d_i.z + ATAN;
      end
      d_o.neg  <= d_i.neg;
      d_o.zero <= d_i.zero;
    end
  end

endmodule

>>> hw/rtl/epr_trig_round.sv
// Sign restore, rounding and clamping of the CORDIC cosine and sine.
module epr_trig_round #(
  parameter int F = 15
) (
  input  logic                clk,
  input  logic                en,
  input  epr_pkg::cordic_t    d_i,
  output logic signed [F+1:0] c_o,
  output logic signed [F+1:0] s_o,
  output logic                zero_o
);

  localparam int SH = 30 - F;
  localparam logic signed [35:0] ONE = 36'sd1 <<< F;

  logic signed [35:0] xn, yn, xr, yr, xc, yc;

  assign xn = d_i.neg ? -36'(d_i.x) : 36'(d_i.x);
  assign yn = d_i.neg ? -36'(d_i.y) : 36'(d_i.y);

  if (SH == 0) begin : g_nornd
    assign xr = xn;
    assign yr = yn;
  end else begin : g_rnd
    assign xr = (xn + (36'sd1 <<< (SH - 1))) >>> SH;
    assign yr = (yn + (36'sd1 <<< (SH - 1))) >>> SH;
  end

  assign xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
  assign yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);

  always_ff @(posedge clk) begin
    if (en) begin
      c_o    <= xc[F+1:0];
      s_o    <= yc[F+1:0];
      zero_o <= d_i.zero;
    end
  end

endmodule

>>> hw/rtl/epr_rotate.sv
// One axis rotation of the point: a product stage and a round and saturate stage.
module epr_rotate #(
  parameter int F    = 15,
  parameter int AXIS = 0
) (
  input  logic                clk,
  input  logic                en,
  input  epr_pkg::point_t     pt_i,
  input  logic signed [F+1:0] c_i,
  input  logic signed [F+1:0] s_i,
  input  logic                zero_i,
  output epr_pkg::point_t     pt_o
);

  localparam int PW = F + 34;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (F - 1);
  localparam logic signed [SW-1:0] SMAX = SW'(64'sd2147483647);
  localparam logic signed [SW-1:0] SMIN = SW'(-64'sd2147483648);

  logic signed [31:0]   u, v;
  logic signed [PW-1:0] cu_r, cv_r, su_r, sv_r;
  epr_pkg::point_t      pt_r;
  logic                 zero_r;
  logic signed [SW-1:0] n1, n2, r1, r2;
  logic signed [31:0]   q1, q2;
  epr_pkg::point_t      pt_nxt;

  assign u = (AXIS == epr_pkg::AXIS_X) ? pt_i.py : pt_i.px;
  assign v = (AXIS == epr_pkg::AXIS_Z) ? pt_i.py : pt_i.pz;

  always_ff @(posedge clk) begin
    if (en) begin
      cu_r   <= PW'(c_i) * PW'(u);
      cv_r   <= PW'(c_i) * PW'(v);
      su_r   <= PW'(s_i) * PW'(u);
      sv_r   <= PW'(s_i) * PW'(v);
      pt_r   <= pt_i;
      zero_r <= zero_i;
    end
  end

  // The Y axis uses the opposite sine sign from X and Z.
  always_comb begin
    if (AXIS == epr_pkg::AXIS_Y) begin
      n1 = SW'(cu_r) - SW'(sv_r);
      n2 = SW'(cv_r) + SW'(su_r);
    end else begin
      n1 = SW'(cu_r) + SW'(sv_r);
      n2 = SW'(cv_r) - SW'(su_r);
    end
    r1 = (n1 + HALF) >>> F;
    r2 = (n2 + HALF) >>> F;
    q1 = (r1 > SMAX) ? 32'sh7fffffff : ((r1 < SMIN) ? 32'sh80000000 : r1[31:0]);
    q2 = (r2 > SMAX) ? 32'sh7fffffff : ((r2 < SMIN) ? 32'sh80000000 : r2[31:0]);
    pt_nxt = pt_r;
    if (!zero_r) begin
      case (AXIS)
        epr_pkg::AXIS_X: begin
          pt_nxt.py = q1;
          pt_nxt.pz = q2;
        end
        epr_pkg::AXIS_Y: begin
          pt_nxt.px = q1;
          pt_nxt.pz = q2;
        end
        default: begin
          pt_nxt.px = q1;
          pt_nxt.py = q2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_o <= pt_nxt;
    end
  end

endmodule

>>> test/testbench.sv
// Self-checking testbench for the Euler X-Y-Z point rotation unit.
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC = 15;
  localparam int ROT_ITERS = 30;
  localparam longint DEG360 = 64'sd23592960;
  localparam longint DEG180 = 64'sd11796480;
  localparam longint DEG90 = 64'sd5898240;
  localparam longint RAD_SCALE = 64'sd307041569099;
  localparam longint START_GAIN = 64'sd652032874;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_angle_x = '0;
  logic signed [31:0] in_angle_y = '0;
  logic signed [31:0] in_angle_z = '0;
  logic signed [31:0] in_point_x = '0;
  logic signed [31:0] in_point_y = '0;
  logic signed [31:0] in_point_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;

  // Rotated points still owed by the unit, oldest first.
  vec3_t rotated_q[$];
  int mismatches = 0;
  // When set, the receiver never stalls; with tx_eager also set, a stretch runs at full rate.
  bit rx_eager = 1'b0;
  bit tx_eager = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  euler_xyz_point_rotate_unit #(.TRIG_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_x(in_angle_x), .in_angle_y(in_angle_y), .in_angle_z(in_angle_z),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_x(out_x), .out_y(out_y), .out_z(out_z)
  );

  // Arctangent of 2^-i in Q2.30 radians.
  function automatic longint arctan_step(input int i);
    longint r;
    case (i)
      0: r = 843314857;
      1: r = 497837829;
      2: r = 263043837;
      3: r = 133525159;
      4: r = 67021687;
      5: r = 33543516;
      6: r = 16775851;
      7: r = 8388437;
      8: r = 4194283;
      9: r = 2097149;
      default: r = longint'(1) <<< (30 - i);
    endcase
    return r;
  endfunction

  // Rounds by n bits: add one half, then shift arithmetically, which floors.
  function automatic longint round_down(input longint v, input int n);
    if (n == 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Cosine and sine of an angle in Q16.16 degrees, at FRAC fraction bits.
  task automatic cos_sin(input longint ang, output longint c, output longint s);
    longint m, cx, sy, z, t, one;
    bit flip;
    m = ang % DEG360;
    flip = 1'b0;
    if (m < 0) m += DEG360;
    if (m >= DEG180) m -= DEG360;
    // Beyond a right angle the angle is folded by half a turn, then the signs flip.
    if (m > DEG90) begin
      m -= DEG180;
      flip = 1'b1;
    end else if (m < -DEG90) begin
      m += DEG180;
      flip = 1'b1;
    end
    z = round_down(m * RAD_SCALE, 30);
    cx = START_GAIN;
    sy = 0;
    for (int i = 0; i < ROT_ITERS; i++) begin
      if (z >= 0) begin
        t = cx - (sy >>> i);
        sy = sy + (cx >>> i);
        z -= arctan_step(i);
      end else begin
        t = cx + (sy >>> i);
        sy = sy - (cx >>> i);
        z += arctan_step(i);
      end
      cx = t;
    end
    if (flip) begin
      cx = -cx;
      sy = -sy;
    end
    cx = round_down(cx, 30 - FRAC);
    sy = round_down(sy, 30 - FRAC);
    one = longint'(1) <<< FRAC;
    if (cx > one) cx = one;
    if (cx < -one) cx = -one;
    if (sy > one) sy = one;
    if (sy < -one) sy = -one;
    c = cx;
    s = sy;
  endtask

  function automatic longint blend(input longint a, input longint p, input longint b,
                                   input longint q);
    return clamp32(round_down(a * p + b * q, FRAC));
  endfunction

  // Applies the X, Y and Z stages in order; a zero angle skips its stage.
  task automatic rotate_point(input logic signed [31:0] ax, input logic signed [31:0] ay,
                              input logic signed [31:0] az, input vec3_t p,
                              output vec3_t r);
    longint px, py, pz, c, s, n1, n2;
    px = p.x;
    py = p.y;
    pz = p.z;
    if (ax != 0) begin
      cos_sin(ax, c, s);
      n1 = blend(c, py, s, pz);
      n2 = blend(c, pz, -s, py);
      py = n1;
      pz = n2;
    end
    if (ay != 0) begin
      cos_sin(ay, c, s);
      n1 = blend(c, px, -s, pz);
      n2 = blend(c, pz, s, px);
      px = n1;
      pz = n2;
    end
    if (az != 0) begin
      cos_sin(az, c, s);
      n1 = blend(c, px, s, py);
      n2 = blend(c, py, -s, px);
      px = n1;
      py = n2;
    end
    r.x = px[31:0];
    r.y = py[31:0];
    r.z = pz[31:0];
  endtask

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Sends one request after a random gap (none when tx_eager is set) and records its expected rotation.
  task automatic send_request(input logic signed [31:0] ax, input logic signed [31:0] ay,
                              input logic signed [31:0] az, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic signed [31:0] pz);
    vec3_t want;
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    in_point_x <= px;
    in_point_y <= py;
    in_point_z <= pz;
    rotate_point(ax, ay, az, '{px, py, pz}, want);
    rotated_q.push_back(want);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // The request was taken at this edge; valid stays up in case the next one follows.
  endtask

  // Receiver: draws a stall length per result and checks each accepted one.
  initial begin
    int hold;
    vec3_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = rx_eager ? 0 : $urandom_range(0, 13);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (rotated_q.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        mismatches++;
      end else begin
        want = rotated_q.pop_front();
        if (out_x !== want.x) report_mismatch("x", out_x, want.x);
        if (out_y !== want.y) report_mismatch("y", out_y, want.y);
        if (out_z !== want.z) report_mismatch("z", out_z, want.z);
      end
    end
  end

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Mostly moderate angles and points, with some multiples of 90 degrees.
  function automatic logic [31:0] some_angle();
    case ($urandom_range(0, 7))
      0: return 32'(($urandom_range(0, 16) - 8) * DEG90);
      1: return 0;
      2: return any_word();
      default: return 32'(int'($urandom_range(0, 2 * 800 * 65536)) - 800 * 65536);
    endcase
  endfunction

  function automatic logic [31:0] some_coord();
    if ($urandom_range(0, 5) == 0) return any_word();
    return 32'(int'($urandom_range(0, 2000000000)) - 1000000000);
  endfunction

  // Drops valid, then waits until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    // Zero angles pass the point through; extremes of every field.
    send_request(0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_request(32'sh005a_0000, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_request(0, 32'sh005a_0000, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    send_request(0, 0, 32'sh005a_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    // Multiples of a full turn still run through their stage.
    send_request(32'sh0168_0000, -32'sh0168_0000, 32'sh02d0_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h8000_0000);
    // Folding across a right angle and half a turn.
    send_request(32'sh00b4_0000, 32'sh005a_0001, -32'sh005a_0001, 32'h1234_5678,
                 -32'sh0765_4321, 32'h0abc_def0);
    send_request(-32'sh00b4_0000, 32'sh010e_0000, 32'sh0087_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000);
    // Saturation: a 45 degree turn of large coordinates.
    send_request(32'sh002d_0000, 32'sh002d_0000, 32'sh002d_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                 32'h8000_0000, 32'h7fff_ffff);
    send_request(32'hffff_ffff, 1, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
    send_request(1, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++)
      send_request(some_angle(), some_angle(), some_angle(), some_coord(), some_coord(),
                   some_coord());
  endtask

  task automatic test_full_rate(input int n);
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    test_random(n);
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(700);
    // The sender holds off until the unit has returned everything.
    wait_drained();
    test_full_rate(300);
    test_random(640);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
